// ----- src/spg_pkg.sv -----
// ----------------------------------------------------------------------------
// spg_pkg
// types, constants and helper functions shared by the sphere point generator
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int DefMaxPoints     = 1024;
  localparam int DefTrigIterations = 16;
  localparam int AtanDepth        = 24;

  localparam int PhaseW = 16;
  localparam int AngW   = 16;
  localparam int CountW = 11;
  localparam int ModeW  = 2;

  // cordic datapath: q2.30 plus guard
  localparam int CordW = 34;

  localparam logic signed [CordW-1:0] Q30Pi      = 34'sd3373259426;
  localparam logic signed [CordW-1:0] Q30HalfPi  = 34'sd1686629713;
  localparam logic signed [CordW-1:0] Q30TwoPi   = 34'sd6746518852;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;

  localparam logic [ModeW-1:0] ModeOwn    = 2'd0;
  localparam logic [ModeW-1:0] ModeSum    = 2'd1;
  localparam logic [ModeW-1:0] ModeSecond = 2'd2;

  typedef struct packed {
    logic [15:0]        phase;
    logic [15:0]        second_phase;
    logic signed [15:0] latitude_low;
    logic signed [15:0] latitude_high;
    logic signed [15:0] longitude_low;
    logic signed [15:0] longitude_high;
    logic [10:0]        point_count;
    logic signed [15:0] sphere_radius;
  } spg_in_t;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } spg_out_t;

  // one rotation cell's working vector
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
  } spg_vec_t;

  function automatic logic signed [CordW-1:0] atan_q30(input int idx);
    logic signed [CordW-1:0] v;
    case (idx)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- src/spg_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// spg_cordic_cell
// one registered rotation-mode cordic step, passes its vector on each cycle that en is high
// ----------------------------------------------------------------------------
module spg_cordic_cell import spg_pkg::*; #(
  parameter int Index = 0
) (
  input  logic     clk,
  input  logic     en,
  input  spg_vec_t vin,
  output spg_vec_t vout
);

  localparam logic signed [CordW-1:0] Atan = atan_q30(Index);

  spg_vec_t vnext;

  always_comb begin
    if (!vin.z[CordW-1]) begin
      vnext.x = vin.x - (vin.y >>> Index);
      vnext.y = vin.y + (vin.x >>> Index);
      vnext.z = vin.z - Atan;
    end else begin
      vnext.x = vin.x + (vin.y >>> Index);
      vnext.y = vin.y - (vin.x >>> Index);
      vnext.z = vin.z + Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout <= vnext;
    end
  end

endmodule

// ----- src/spg_sincos.sv -----
// ----------------------------------------------------------------------------
// spg_sincos
// range reduction then a chain of cordic cells, sin and cos in q2.30
// ----------------------------------------------------------------------------
module spg_sincos import spg_pkg::*; #(
  parameter int TrigIterations = DefTrigIterations
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AngW-1:0]  angle,
  output logic signed [CordW-1:0] sin_q,
  output logic signed [CordW-1:0] cos_q
);

  localparam int N = (TrigIterations > AtanDepth) ? AtanDepth : TrigIterations;

  logic signed [CordW-1:0] z0, z1, zr;
  logic                    fold;
  spg_vec_t                chain [N+1];
  logic                    neg_line [N+1];

  // q4.12 range is below 3*pi, so at most one 2pi step each way
  always_comb begin
    z0 = CordW'(angle) <<< 18;
    if (z0 > Q30Pi) begin
      z1 = z0 - Q30TwoPi;
    end else if (z0 < -Q30Pi) begin
      z1 = z0 + Q30TwoPi;
    end else begin
      z1 = z0;
    end
    fold = 1'b0;
    zr = z1;
    if (z1 > Q30HalfPi) begin
      zr = z1 - Q30Pi;
      fold = 1'b1;
    end else if (z1 < -Q30HalfPi) begin
      zr = z1 + Q30Pi;
      fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0]    <= '{x: CordicGain, y: '0, z: zr};
      neg_line[0] <= fold;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    spg_cordic_cell #(.Index(i)) u_cell (
      .clk (clk),
      .en  (en),
      .vin (chain[i]),
      .vout(chain[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        neg_line[i+1] <= neg_line[i];
      end
    end
  end

  assign sin_q = neg_line[N] ? -chain[N].y : chain[N].y;
  assign cos_q = neg_line[N] ? -chain[N].x : chain[N].x;

endmodule

// ----- src/sphere_point_generator.sv -----
// ----------------------------------------------------------------------------
// sphere_point_generator
// spherical to cartesian point generator, one coordinate triple per sample
// ----------------------------------------------------------------------------
// usage: in_valid/in_stall carry one sample struct; out_valid/out_stall carry
// the x, y, z result. a transfer happens on a clock edge with valid high and
// stall low. phase_mode_we/phase_mode_data write the longitude phase mode;
// write only while the pipe is empty.
// throughput: one transfer per cycle while out_stall is low.
// stages: the fraction, interpolation and cordic load registers, the cordic
// cell chain, two multiply stages and the output register.
// the whole pipe advances together; when out_stall holds a full output
// register the pipe freezes and in_stall is raised, so in_stall follows
// out_stall while the output holds a result.
// rst clears the mode to own wrap and empties the pipe.
// ----------------------------------------------------------------------------
module sphere_point_generator import spg_pkg::*; #(
  parameter int MAX_POINTS      = DefMaxPoints,
  parameter int TRIG_ITERATIONS = DefTrigIterations
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  spg_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output spg_out_t         out_data,
  input  logic             phase_mode_we,
  input  logic [ModeW-1:0] phase_mode_data
);

  localparam int NIt   = (TRIG_ITERATIONS > AtanDepth) ? AtanDepth : TRIG_ITERATIONS;
  localparam int CosLat = 3;
  localparam int Depth = NIt + 6;
  localparam int NW    = $clog2(MAX_POINTS + 1) + 1;

  logic [ModeW-1:0] mode;
  logic             en;
  logic [Depth-1:0] vld;

  assign en       = !(vld[Depth-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeOwn;
    end else if (phase_mode_we) begin
      mode <= (phase_mode_data > ModeSecond) ? ModeOwn : phase_mode_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // stage 1: fraction
  logic [NW-1:0]      n_sel;
  logic [15:0]        frac_next;
  logic [15:0]        s1_frac, s1_ph;
  logic signed [15:0] s1_lat_lo, s1_lat_hi, s1_lon_lo, s1_lon_hi, s1_r;
  logic [15+NW:0]     prod_n;

  always_comb begin
    if (in_data.point_count == '0) begin
      n_sel = NW'(1);
    end else if (32'(in_data.point_count) > MAX_POINTS) begin
      n_sel = NW'(MAX_POINTS);
    end else begin
      n_sel = NW'(in_data.point_count);
    end
    prod_n = (mode == ModeSecond) ? (16+NW)'(in_data.second_phase) * (16+NW)'(n_sel)
                                  : (16+NW)'(in_data.phase) * (16+NW)'(n_sel);
    frac_next = prod_n[15:0] + ((mode == ModeSum) ? in_data.second_phase : 16'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_frac   <= frac_next;
      s1_ph     <= in_data.phase;
      s1_lat_lo <= in_data.latitude_low;
      s1_lat_hi <= in_data.latitude_high;
      s1_lon_lo <= in_data.longitude_low;
      s1_lon_hi <= in_data.longitude_high;
      s1_r      <= in_data.sphere_radius;
    end
  end

  // stage 2: interpolation
  logic signed [16:0] dlat, dlon;
  logic signed [34:0] plat, plon;
  logic signed [15:0] lat_a, lon_a;

  always_comb begin
    dlat = 17'(s1_lat_hi) - 17'(s1_lat_lo);
    dlon = 17'(s1_lon_hi) - 17'(s1_lon_lo);
    plat = 35'(dlat) * $signed({19'd0, s1_ph}) + 35'sd32768;
    plon = 35'(dlon) * $signed({19'd0, s1_frac}) + 35'sd32768;
    lat_a = s1_lat_lo + plat[31:16];
    lon_a = s1_lon_lo + plon[31:16];
  end

  logic signed [15:0] s2_lat, s2_lon;
  logic signed [15:0] r_line [NIt+3];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lat    <= lat_a;
      s2_lon    <= lon_a;
      r_line[0] <= s1_r;
      for (int k = 1; k < NIt + 3; k++) begin
        r_line[k] <= r_line[k-1];
      end
    end
  end

  logic signed [CordW-1:0] slat, clat, slon, clon;

  spg_sincos #(.TrigIterations(NIt)) u_lat (
    .clk(clk), .en(en), .angle(s2_lat), .sin_q(slat), .cos_q(clat));
  spg_sincos #(.TrigIterations(NIt)) u_lon (
    .clk(clk), .en(en), .angle(s2_lon), .sin_q(slon), .cos_q(clon));

  // product stages
  logic signed [67:0] pxc, pxs;
  logic signed [CordW-1:0] m_x, m_y, m_cl;

  always_comb begin
    pxc = 68'(slat) * 68'(clon) + (68'sd1 <<< 29);
    pxs = 68'(slat) * 68'(slon) + (68'sd1 <<< 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_x  <= pxc[30+CordW-1:30];
      m_y  <= pxs[30+CordW-1:30];
      m_cl <= clat;
    end
  end

  logic signed [CordW-1:0] m2_x, m2_y, m2_cl;
  logic signed [15:0]      r_m;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_x  <= m_x;
      m2_y  <= m_y;
      m2_cl <= m_cl;
      r_m   <= r_line[NIt+CosLat-1];
    end
  end

  logic signed [50:0] rx, ry, rz;

  always_comb begin
    rx = 51'(r_m) * 51'(m2_x) + (51'sd1 <<< 29);
    ry = 51'(r_m) * 51'(m2_y) + (51'sd1 <<< 29);
    rz = 51'(r_m) * 51'(m2_cl) + (51'sd1 <<< 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.coord_x <= sat16(48'(rx >>> 30));
      out_data.coord_y <= sat16(48'(ry >>> 30));
      out_data.coord_z <= sat16(48'(rz >>> 30));
    end
  end

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode <= ModeSecond)
    else $error("illegal phase mode stored");

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sphere point generator: a local fixed-point
// model predicts each coordinate triple, results are compared in order while
// both handshake sides idle and stall at random across all phase modes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import spg_pkg::*;

  localparam int Latency = DefTrigIterations + 6;
  localparam longint PiQ30 = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint TwoPiQ30 = 64'sd6746518852;
  localparam longint GainQ30 = 64'sd652032874;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  spg_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spg_out_t out_data;
  logic phase_mode_we = 1'b0;
  logic [ModeW-1:0] phase_mode_data = ModeOwn;

  logic [ModeW-1:0] mode_shadow = ModeOwn;
  spg_out_t expected_coords[$];
  int fail_count = 0;
  bit stall_enable = 1'b1;

  sphere_point_generator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .phase_mode_we(phase_mode_we), .phase_mode_data(phase_mode_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_off(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                      33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                      524287, 262143, 131071, 65535, 32767};
    return t[i];
  endfunction

  task automatic rotate_angle(input longint ang, output longint s, output longint c);
    longint z, x, y, t;
    bit flip;
    z = ang * 262144;
    x = GainQ30;
    y = 0;
    flip = 1'b0;
    while (z > PiQ30) z -= TwoPiQ30;
    while (z < -PiQ30) z += TwoPiQ30;
    if (z > HalfPiQ30) begin
      z -= PiQ30;
      flip = 1'b1;
    end else if (z < -HalfPiQ30) begin
      z += PiQ30;
      flip = 1'b1;
    end
    for (int i = 0; i < DefTrigIterations; i++) begin
      if (z >= 0) begin
        t = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_entry(i);
      end else begin
        t = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_entry(i);
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic predict_coords(input spg_in_t s, output spg_out_t o);
    longint n, frac, lat, lon, slat, clat, slon, clon, r, ph, ph2;
    n = s.point_count;
    if (n == 0) n = 1;
    if (n > DefMaxPoints) n = DefMaxPoints;
    ph = s.phase;
    ph2 = s.second_phase;
    if (mode_shadow == ModeSum) frac = ph * n + ph2;
    else if (mode_shadow == ModeSecond) frac = ph2 * n;
    else frac = ph * n;
    frac &= 64'hffff;
    lat = longint'(s.latitude_low)
        + round_off((longint'(s.latitude_high) - s.latitude_low) * ph, 16);
    lon = longint'(s.longitude_low)
        + round_off((longint'(s.longitude_high) - s.longitude_low) * frac, 16);
    rotate_angle(lat, slat, clat);
    rotate_angle(lon, slon, clon);
    r = s.sphere_radius;
    o.coord_x = clip16(round_off(r * round_off(slat * clon, 30), 30));
    o.coord_y = clip16(round_off(r * round_off(slat * slon, 30), 30));
    o.coord_z = clip16(round_off(r * clat, 30));
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
  endfunction

  // receive side: random stall, in-order compare
  initial begin
    int wait_cycles;
    spg_out_t exp_c;
    wait_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_coords.size() == 0) begin
          $error("unexpected transfer x=%0d y=%0d z=%0d",
                 out_data.coord_x, out_data.coord_y, out_data.coord_z);
          fail_count++;
        end else begin
          exp_c = expected_coords.pop_front();
          if (out_data.coord_x !== exp_c.coord_x) begin
            $error("coord_x expected %0d actual %0d", exp_c.coord_x, out_data.coord_x);
            fail_count++;
          end
          if (out_data.coord_y !== exp_c.coord_y) begin
            $error("coord_y expected %0d actual %0d", exp_c.coord_y, out_data.coord_y);
            fail_count++;
          end
          if (out_data.coord_z !== exp_c.coord_z) begin
            $error("coord_z expected %0d actual %0d", exp_c.coord_z, out_data.coord_z);
            fail_count++;
          end
        end
      end
      if (wait_cycles > 0) begin
        wait_cycles--;
        out_stall <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        wait_cycles = rand_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(input spg_in_t s, input bit gaps);
    spg_out_t o;
    int g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    predict_coords(s, o);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_coords.push_back(o);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [ModeW-1:0] v);
    drain_pipe();
    phase_mode_we <= 1'b1;
    phase_mode_data <= v;
    @(posedge clk);
    phase_mode_we <= 1'b0;
    mode_shadow = (v > ModeSecond) ? ModeOwn : v;
  endtask

  function automatic spg_in_t rand_sample();
    spg_in_t s;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    s = raw[$bits(spg_in_t)-1:0];
    case ($urandom_range(0, 3))
      0: s.point_count = $urandom_range(0, 16);
      1: s.point_count = $urandom_range(1020, 1024);
      2: s.point_count = $urandom_range(0, 2047);
      default: s.point_count = $urandom_range(0, 1024);
    endcase
    return s;
  endfunction

  task automatic test_extremes();
    spg_in_t s;
    logic [15:0] ph [4] = '{16'h0000, 16'hffff, 16'h8000, 16'h4000};
    for (int i = 0; i < 4; i++) begin
      s.phase = ph[i];
      s.second_phase = ph[3 - i];
      s.latitude_low = (i[0]) ? 16'sh8000 : 16'sh0000;
      s.latitude_high = (i[1]) ? 16'sh7fff : 16'sh3244;
      s.longitude_low = (i[0]) ? 16'sh7fff : 16'sh8000;
      s.longitude_high = (i[1]) ? 16'sh8000 : 16'sh6488;
      s.point_count = (i == 0) ? 11'd0 : (i == 1) ? 11'd2047 : (i == 2) ? 11'd1024 : 11'd1;
      s.sphere_radius = (i[0]) ? 16'sh8000 : 16'sh7fff;
      send_sample(s, 1'b0);
    end
    s = '0;
    s.sphere_radius = 16'sh4000;
    s.point_count = 11'd1025;
    send_sample(s, 1'b0);
    s.latitude_low = 16'sh1922;
    s.latitude_high = 16'sh1922;
    send_sample(s, 1'b0);
  endtask

  task automatic test_modes();
    logic [ModeW-1:0] seq [5] = '{ModeSum, ModeSecond, 2'd3, ModeSecond, ModeOwn};
    foreach (seq[m]) begin
      write_mode(seq[m]);
      repeat (4) send_sample(rand_sample(), 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    for (int blk = 0; blk < 9; blk++) begin
      write_mode(logic'($urandom_range(0, 3)) ? ModeW'($urandom_range(0, 3)) : ModeOwn);
      stall_enable = (blk % 3 != 2);
      repeat (100) send_sample(rand_sample(), stall_enable);
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_modes();
    test_random_traffic();
    drain_pipe();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sphere_point_generator.f -----
src/spg_pkg.sv
src/spg_cordic_cell.sv
src/spg_sincos.sv
src/sphere_point_generator.sv
dv/tb_top.sv
